@@ design/accel_record_ring_fifo_core_assert.svh @@
// assertion macros for the accel record ring fifo checker
// no dependencies; included by the checker file only
`ifndef ACCEL_RECORD_RING_FIFO_CORE_ASSERT_SVH
`define ACCEL_RECORD_RING_FIFO_CORE_ASSERT_SVH

// clocked assertion, switched off while reset is held
`define ARF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also checks across reset
`define ARF_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/arf_pkg.sv @@
// shared types and constants for the accel record ring fifo
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package arf_pkg;

  localparam int FIFO_BYTES = 1080;
  localparam int PTR_W      = $clog2(FIFO_BYTES);
  localparam int REC_BYTES  = 6;
  localparam int HR_BATCH   = 60;
  localparam int BO_BATCH   = 15;
  localparam int CNT_W      = 6;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_HR   = 2'd1,
    MODE_BO   = 2'd2
  } mode_t;

  typedef enum logic {
    CFG_ENABLE = 1'b0,
    CFG_MODE   = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_LOAD  = 4'b0100,
    S_EMPTY = 4'b1000
  } state_t;

endpackage

`default_nettype wire

@@ design/accel_record_ring_fifo_core.sv @@
// accel record ring fifo: byte ring in one synchronous ram, record unpacking
// depends on arf_pkg
// write and clear words are taken as they arrive; a read batch is sized on acceptance,
// then each record takes 6 byte reads on the single ram port, the registered ram read
// and a load of the output register; an empty read goes through S_EMPTY to the output
// register. sync reset clears pointers, count and control registers;
// the ram is not swept: entries past the fill mark read as zero
`timescale 1ns / 1ps
`default_nettype none

module accel_record_ring_fifo_core import arf_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration port
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [1:0]          cfg_wdata,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_kind,
  input  wire logic [7:0]          in_data_byte,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_has_record,
  output logic signed [15:0]       out_x_axis,
  output logic signed [15:0]       out_y_axis,
  output logic signed [15:0]       out_z_axis,
  output logic [CNT_W-1:0]         out_record_count,
  output logic                     out_last
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_BYTES - 1);
  localparam logic [2:0]       REC_N    = 3'(REC_BYTES);
  localparam logic [2:0]       REC_LAST = 3'(REC_BYTES - 1);

  // configuration registers
  logic       enable_r;
  logic [1:0] mode_r;

  // ring state
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic             wrapped_r, wrapped_nxt;   // every entry written since clear
  logic [31:0]      unread_r, unread_nxt;

  // batch sequencer
  state_t           state_r, state_nxt;
  logic [2:0]       iss_r, iss_nxt;           // byte reads issued for this record
  logic [2:0]       got_r, got_nxt;           // bytes received for this record
  logic             rd_pend_r, rd_pend_nxt;   // ram data arrives this cycle
  logic [CNT_W-1:0] recs_left_r, recs_left_nxt;
  logic [CNT_W-1:0] batch_n_r, batch_n_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload
  logic [7:0]  mem [FIFO_BYTES];
  logic [7:0]  mem_q_r;
  logic        rd_ok_r;                       // entry read was written since clear
  logic [47:0] rec_r;
  logic        has_rec_r;
  logic [15:0] x_r, y_r, z_r;
  logic [CNT_W-1:0] cnt_r;
  logic        last_r;

  logic mem_we, mem_re, load_rec, load_empty, out_free;
  logic [PTR_W-1:0] wr_ptr_inc, rd_ptr_inc;
  logic [7:0]  rd_byte;

  // batch sizing
  logic [CNT_W-1:0] lim_recs;
  logic [8:0]       lim_bytes;
  logic [16:0]      small_prod;
  logic [CNT_W-1:0] avail_n;
  logic [8:0]       batch_bytes;

  assign wr_ptr_inc = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_inc = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;

  // records per batch: none when disabled or with no valid mode, else full batch when enough bytes, else unread / 6
  always_comb begin
    lim_recs  = '0;
    lim_bytes = '0;
    if (enable_r) begin
      case (mode_r)
        MODE_HR: begin
          lim_recs  = CNT_W'(HR_BATCH);
          lim_bytes = 9'(HR_BATCH * REC_BYTES);
        end
        MODE_BO: begin
          lim_recs  = CNT_W'(BO_BATCH);
          lim_bytes = 9'(BO_BATCH * REC_BYTES);
        end
        default: begin
          lim_recs  = '0;
          lim_bytes = '0;
        end
      endcase
    end
  end

  // below 360 bytes, x*171 >> 10 equals x/6 exactly
  assign small_prod  = 17'(unread_r[8:0]) * 17'd171;
  assign avail_n     = (unread_r >= 32'(lim_bytes)) ? lim_recs : small_prod[15:10];
  assign batch_bytes = 9'({avail_n, 2'b00}) + 9'({avail_n, 1'b0});

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    wrapped_nxt   = wrapped_r;
    unread_nxt    = unread_r;
    state_nxt     = state_r;
    iss_nxt       = iss_r;
    got_nxt       = got_r;
    rd_pend_nxt   = 1'b0;
    recs_left_nxt = recs_left_r;
    batch_n_nxt   = batch_n_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    load_rec      = 1'b0;
    load_empty    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            KIND_WRITE: begin
              if (enable_r) begin
                mem_we     = 1'b1;
                wr_ptr_nxt = wr_ptr_inc;
                if (wr_ptr_r == PTR_LAST) begin
                  wrapped_nxt = 1'b1;
                end
                if (unread_r != '1) begin
                  unread_nxt = unread_r + 1'b1;
                end
              end
            end
            KIND_READ: begin
              if (avail_n == '0) begin
                state_nxt = S_EMPTY;
              end else begin
                batch_n_nxt   = avail_n;
                recs_left_nxt = avail_n;
                unread_nxt    = unread_r - 32'(batch_bytes);
                iss_nxt       = '0;
                got_nxt       = '0;
                state_nxt     = S_READ;
              end
            end
            KIND_CLEAR: begin
              wr_ptr_nxt  = '0;
              rd_ptr_nxt  = '0;
              wrapped_nxt = 1'b0;
              unread_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        // one byte read a cycle through the single ram port
        if (iss_r != REC_N) begin
          mem_re      = 1'b1;
          rd_ptr_nxt  = rd_ptr_inc;
          iss_nxt     = iss_r + 1'b1;
          rd_pend_nxt = 1'b1;
        end
        if (rd_pend_r) begin
          got_nxt = got_r + 1'b1;
          if (got_r == REC_LAST) begin
            state_nxt = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        if (out_free) begin
          load_rec      = 1'b1;
          out_valid_nxt = 1'b1;
          recs_left_nxt = recs_left_r - 1'b1;
          if (recs_left_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            iss_nxt   = '0;
            got_nxt   = '0;
            state_nxt = S_READ;
          end
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          load_empty    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      mode_r      <= MODE_NONE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      wrapped_r   <= 1'b0;
      unread_r    <= '0;
      state_r     <= S_IDLE;
      iss_r       <= '0;
      got_r       <= '0;
      rd_pend_r   <= 1'b0;
      recs_left_r <= '0;
      batch_n_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE: enable_r <= cfg_wdata[0];
          CFG_MODE:   mode_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wrapped_r   <= wrapped_nxt;
      unread_r    <= unread_nxt;
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      got_r       <= got_nxt;
      rd_pend_r   <= rd_pend_nxt;
      recs_left_r <= recs_left_nxt;
      batch_n_r   <= batch_n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ring ram, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr_r] <= in_data_byte;
    end
    if (mem_re) begin
      mem_q_r <= mem[rd_ptr_r];
      rd_ok_r <= wrapped_r || (rd_ptr_r < wr_ptr_r);
    end
  end

  // entries not written since the last clear read as zero
  assign rd_byte = rd_ok_r ? mem_q_r : 8'h00;

  // record assembly and output word
  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      rec_r <= {rd_byte, rec_r[47:8]};
    end
    if (load_rec) begin
      has_rec_r <= 1'b1;
      x_r       <= rec_r[15:0];
      y_r       <= rec_r[31:16];
      z_r       <= rec_r[47:32];
      cnt_r     <= batch_n_r;
      last_r    <= (recs_left_r == CNT_W'(1));
    end else if (load_empty) begin
      has_rec_r <= 1'b0;
      x_r       <= '0;
      y_r       <= '0;
      z_r       <= '0;
      cnt_r     <= '0;
      last_r    <= 1'b1;
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_has_record   = has_rec_r;
  assign out_x_axis       = x_r;
  assign out_y_axis       = y_r;
  assign out_z_axis       = z_r;
  assign out_record_count = cnt_r;
  assign out_last         = last_r;

endmodule

`default_nettype wire

@@ design/arf_checker.sv @@
// port-level checks for the accel record ring fifo, bound to the top level
// depends on arf_pkg and accel_record_ring_fifo_core_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "accel_record_ring_fifo_core_assert.svh"

module arf_checker import arf_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic              out_has_record,
  input wire logic signed [15:0] out_x_axis,
  input wire logic [CNT_W-1:0]  out_record_count,
  input wire logic              out_last
);

  // a waiting word holds
  `ARF_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_x_axis), "output word changed while stalled")

  // an empty read is a single closing word with zero count
  `ARF_ASSERT(a_empty_word, clk, rst_n, out_valid && !out_has_record |-> out_last && (out_record_count == '0), "empty word malformed")

  // a record word belongs to a batch of 1 to 60 records
  `ARF_ASSERT(a_rec_count, clk, rst_n, out_valid && out_has_record |-> (out_record_count != '0) && (out_record_count <= CNT_W'(HR_BATCH)), "record count out of range")

  // reset leaves the block ready and with nothing to deliver
  `ARF_ASSERT_NR(a_reset_idle, clk, !rst_n |=> !in_stall && !out_valid, "block busy after reset")

endmodule

bind accel_record_ring_fifo_core arf_checker u_arf_checker (.*);

`default_nettype wire

@@ test/tb.sv @@
// testbench for accel_record_ring_fifo_core: byte writes, record reads, clears, register writes
// checks every result word against a predictor of the byte ring; depends on arf_pkg
`timescale 1ns / 1ps

module tb;
  import arf_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam longint LIMIT_NS  = 64'd1_000_000 * CLK_PERIOD;
  localparam int SETTLE_CYCLES = 4;    // pause after draining so a write or clear word is done
  localparam int TAIL_CYCLES   = 24;
  localparam int RANDOM_ITEMS  = 240;
  localparam int TAIL_RECORDS  = 4;
  localparam int CFG_EVERY     = 40;
  localparam int DIR_ROWS      = 31;
  localparam int MAX_PRINTS    = 50;

  // codes with no member in the package enums
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // one result word, fields in port order
  typedef struct packed {
    logic              has_record;
    logic signed [15:0] x_axis;
    logic signed [15:0] y_axis;
    logic signed [15:0] z_axis;
    logic [CNT_W-1:0]  record_count;
    logic              last;
  } word_t;

  localparam word_t NO_WORD      = '0;
  localparam word_t EMPTY_WORD   = '{1'b0, 16'sd0, 16'sd0, 16'sd0, 6'd0, 1'b1};
  // bytes 00 80 ff 7f 01 ff: most negative x, most positive y, z of -255
  localparam word_t EXTREME_WORD = '{1'b1, 16'sh8000, 16'sh7fff, 16'shff01, 6'd1, 1'b1};

  // one row of the directed script: a register write or an input word
  typedef struct packed {
    logic       is_cfg;
    cfg_idx_t   reg_sel;
    logic [1:0] reg_val;
    logic [1:0] kind;
    logic [7:0] data;
    logic       typed;
    word_t      want;
  } script_row_t;

  localparam script_row_t OPENING_SCRIPT [DIR_ROWS] = '{
    // straight out of reset: disabled, no mode
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_READ,  8'h00, 1'b1, EMPTY_WORD},
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_WRITE, 8'haa, 1'b0, NO_WORD},
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_READ,  8'hff, 1'b1, EMPTY_WORD},
    '{1'b1, CFG_ENABLE, 2'd1,       KIND_WRITE, 8'h00, 1'b0, NO_WORD},
    // one record of extreme axes
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_WRITE, 8'h00, 1'b0, NO_WORD},
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_WRITE, 8'h80, 1'b0, NO_WORD},
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_WRITE, 8'hff, 1'b0, NO_WORD},
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_WRITE, 8'h7f, 1'b0, NO_WORD},
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_WRITE, 8'h01, 1'b0, NO_WORD},
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_WRITE, 8'hff, 1'b0, NO_WORD},
    // enabled but no mode, then the unused mode: both read empty
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_READ,  8'h00, 1'b1, EMPTY_WORD},
    '{1'b1, CFG_MODE,   MODE_SPARE, KIND_WRITE, 8'h00, 1'b0, NO_WORD},
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_READ,  8'h00, 1'b1, EMPTY_WORD},
    '{1'b1, CFG_MODE,   MODE_HR,    KIND_WRITE, 8'h00, 1'b0, NO_WORD},
    // unused kind gives nothing
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_SPARE, 8'h55, 1'b0, NO_WORD},
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_READ,  8'h00, 1'b1, EXTREME_WORD},
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_READ,  8'h00, 1'b1, EMPTY_WORD},
    // a clear drops a part record
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_WRITE, 8'h12, 1'b0, NO_WORD},
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_CLEAR, 8'h00, 1'b0, NO_WORD},
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_READ,  8'h00, 1'b1, EMPTY_WORD},
    // clear while disabled
    '{1'b1, CFG_ENABLE, 2'd0,       KIND_WRITE, 8'h00, 1'b0, NO_WORD},
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_CLEAR, 8'hff, 1'b0, NO_WORD},
    '{1'b1, CFG_ENABLE, 2'd1,       KIND_WRITE, 8'h00, 1'b0, NO_WORD},
    '{1'b1, CFG_MODE,   MODE_BO,    KIND_WRITE, 8'h00, 1'b0, NO_WORD},
    // oxygen mode record, left to the predictor
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_WRITE, 8'h5a, 1'b0, NO_WORD},
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_WRITE, 8'hc3, 1'b0, NO_WORD},
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_WRITE, 8'h0f, 1'b0, NO_WORD},
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_WRITE, 8'hf0, 1'b0, NO_WORD},
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_WRITE, 8'h96, 1'b0, NO_WORD},
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_WRITE, 8'h69, 1'b0, NO_WORD},
    '{1'b0, CFG_ENABLE, 2'd0,       KIND_READ,  8'h00, 1'b0, NO_WORD}
  };

  // dut inputs, all known from time zero
  logic       clk;
  logic       rst_n        = 1'b0;
  logic       cfg_we       = 1'b0;
  cfg_idx_t   cfg_index    = CFG_ENABLE;
  logic [1:0] cfg_wdata    = 2'd0;
  logic       in_valid     = 1'b0;
  logic [1:0] in_kind      = KIND_WRITE;
  logic [7:0] in_data_byte = 8'd0;
  logic       out_stall    = 1'b0;

  logic              in_stall;
  logic              out_valid;
  logic              out_has_record;
  logic signed [15:0] out_x_axis;
  logic signed [15:0] out_y_axis;
  logic signed [15:0] out_z_axis;
  logic [CNT_W-1:0]  out_record_count;
  logic              out_last;

  accel_record_ring_fifo_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_has_record   (out_has_record),
    .out_x_axis       (out_x_axis),
    .out_y_axis       (out_y_axis),
    .out_z_axis       (out_z_axis),
    .out_record_count (out_record_count),
    .out_last         (out_last)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // predictor copy of the ring, its pointers, its count and the two registers
  logic [7:0]  ring_img [FIFO_BYTES];
  int unsigned img_wr_ptr;
  int unsigned img_rd_ptr;
  int unsigned img_unread;
  logic        img_en;
  logic [1:0]  img_mode;

  word_t batch_words [$];   // words produced by the word just accepted
  word_t due_words [$];     // words still owed by the dut, oldest first

  int unsigned fault_count;
  int unsigned sent_words;
  bit          calm;        // final stretch: no idling on either side
  int unsigned tx_rate;
  int unsigned rx_rate;
  int unsigned rx_hold;
  int unsigned rx_cycle;

  task automatic note_fault(input string msg);
    if (fault_count < MAX_PRINTS)
      $display("%0t mismatch: %s", $realtime, msg);
    fault_count++;
  endtask

  task automatic clear_ring_img();
    foreach (ring_img[i])
      ring_img[i] = 8'd0;
    img_wr_ptr = 0;
    img_rd_ptr = 0;
    img_unread = 0;
  endtask

  // work out the words one accepted input word gives, and move the ring image on
  task automatic ring_predict(input logic [1:0] kind, input logic [7:0] data);
    int unsigned lim;
    int unsigned avail;
    int unsigned n;
    logic [7:0]  rec [REC_BYTES];
    word_t       w;
    batch_words.delete();
    case (kind)
      KIND_WRITE: begin
        if (img_en) begin
          ring_img[img_wr_ptr] = data;
          img_wr_ptr = (img_wr_ptr + 1 == FIFO_BYTES) ? 0 : img_wr_ptr + 1;
          // count saturates rather than wrapping
          if (img_unread != 32'hffff_ffff)
            img_unread++;
        end
      end
      KIND_CLEAR: begin
        clear_ring_img();
      end
      KIND_READ: begin
        lim = 0;
        if (img_en) begin
          if (img_mode == MODE_HR)
            lim = HR_BATCH;
          else if (img_mode == MODE_BO)
            lim = BO_BATCH;
        end
        avail = img_unread / REC_BYTES;
        n = (avail < lim) ? avail : lim;
        if (n == 0) begin
          batch_words.push_back(EMPTY_WORD);
        end else begin
          for (int unsigned r = 0; r < n; r++) begin
            // byte by byte with wrap, so a record across the end still fills one word
            for (int m = 0; m < REC_BYTES; m++) begin
              rec[m] = ring_img[img_rd_ptr];
              img_rd_ptr = (img_rd_ptr + 1 == FIFO_BYTES) ? 0 : img_rd_ptr + 1;
            end
            w.has_record   = 1'b1;
            w.x_axis       = {rec[1], rec[0]};
            w.y_axis       = {rec[3], rec[2]};
            w.z_axis       = {rec[5], rec[4]};
            w.record_count = n[CNT_W-1:0];
            w.last         = (r + 1 == n);
            batch_words.push_back(w);
          end
          img_unread -= n * REC_BYTES;
        end
      end
      default: ;  // unused kind: nothing happens
    endcase
  endtask

  // hold off the sender until every owed word is in, then let writes settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t sel, input logic [1:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    case (sel)
      CFG_ENABLE: img_en = val[0];
      CFG_MODE:   img_mode = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
  endtask

  // offer one input word; valid is left high so back-to-back words need no drop
  task automatic send_word(input logic [1:0] kind, input logic [7:0] data,
                           input bit typed = 1'b0, input word_t want = NO_WORD);
    int unsigned gap;
    if (!calm && $urandom_range(0, 15) < tx_rate) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_data_byte <= data;
    do
      @(posedge clk);
    while (in_stall);
    ring_predict(kind, data);
    // rows with a typed answer stand in for the predictor's words
    if (typed)
      due_words.push_back(want);
    else
      foreach (batch_words[i])
        due_words.push_back(batch_words[i]);
    sent_words++;
  endtask

  task automatic check_word();
    word_t got;
    word_t want;
    got = '{out_has_record, out_x_axis, out_y_axis, out_z_axis, out_record_count, out_last};
    if (due_words.size() == 0) begin
      note_fault($sformatf("word with nothing owed: has=%0b x=%0d y=%0d z=%0d cnt=%0d last=%0b",
                           got.has_record, got.x_axis, got.y_axis, got.z_axis,
                           got.record_count, got.last));
      return;
    end
    want = due_words.pop_front();
    if (got.has_record !== want.has_record)
      note_fault($sformatf("has_record %0b, want %0b", got.has_record, want.has_record));
    if (got.x_axis !== want.x_axis)
      note_fault($sformatf("x_axis %0d, want %0d", got.x_axis, want.x_axis));
    if (got.y_axis !== want.y_axis)
      note_fault($sformatf("y_axis %0d, want %0d", got.y_axis, want.y_axis));
    if (got.z_axis !== want.z_axis)
      note_fault($sformatf("z_axis %0d, want %0d", got.z_axis, want.z_axis));
    if (got.record_count !== want.record_count)
      note_fault($sformatf("record_count %0d, want %0d", got.record_count, want.record_count));
    if (got.last !== want.last)
      note_fault($sformatf("last %0b, want %0b", got.last, want.last));
  endtask

  // result side: take words, and stall in bursts whose density drifts
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      check_word();
    rx_cycle++;
    if (rx_cycle % 256 == 0)
      rx_rate = $urandom_range(0, 3);
    if (rx_hold != 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end else if (!calm && rx_rate != 0 && $urandom_range(0, 15) < rx_rate) begin
      rx_hold = $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned next_cfg_at;
    int unsigned nrec;
    int unsigned extra;
    logic        en_pick;
    logic [1:0]  mode_pick;

    clear_ring_img();
    img_en      = 1'b0;
    img_mode    = MODE_NONE;
    fault_count = 0;
    sent_words  = 0;
    calm        = 1'b0;
    tx_rate     = 2;
    rx_rate     = 2;
    rx_hold     = 0;
    rx_cycle    = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed opening
    foreach (OPENING_SCRIPT[i]) begin
      if (OPENING_SCRIPT[i].is_cfg)
        write_reg(OPENING_SCRIPT[i].reg_sel, OPENING_SCRIPT[i].reg_val);
      else
        send_word(OPENING_SCRIPT[i].kind, OPENING_SCRIPT[i].data,
                  OPENING_SCRIPT[i].typed, OPENING_SCRIPT[i].want);
    end

    // random part: mostly whole records followed by a read, some noise in between
    sent_words  = 0;
    next_cfg_at = 0;
    while (sent_words < RANDOM_ITEMS) begin
      if (sent_words >= next_cfg_at) begin
        en_pick = ($urandom_range(0, 4) != 0);
        case ($urandom_range(0, 7))
          0:       mode_pick = MODE_NONE;
          1:       mode_pick = MODE_SPARE;
          2, 3, 4: mode_pick = MODE_HR;
          default: mode_pick = MODE_BO;
        endcase
        write_reg(CFG_ENABLE, {1'b0, en_pick});
        write_reg(CFG_MODE, mode_pick);
        tx_rate = $urandom_range(0, 3);
        next_cfg_at = sent_words + CFG_EVERY;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          // a batch of whole records, sometimes enough to hit the oxygen limit
          nrec = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 18) : $urandom_range(0, 3);
          extra = $urandom_range(0, 1) ? $urandom_range(1, 5) : 0;
          repeat (nrec * REC_BYTES + extra)
            send_word(KIND_WRITE, $urandom_range(0, 255));
          send_word(KIND_READ, $urandom_range(0, 255));
        end
        6: send_word(KIND_READ, $urandom_range(0, 255));
        7: send_word(KIND_CLEAR, $urandom_range(0, 255));
        8: send_word(KIND_SPARE, $urandom_range(0, 255));
        default: begin
          // sender waits for the ring to drain, then a few stray bytes
          wait_drained();
          repeat ($urandom_range(1, 3))
            send_word(KIND_WRITE, $urandom_range(0, 255));
        end
      endcase
    end

    // last part, no idling: a few records back to back, read out in heart-rate batches
    // until less than one record is left
    write_reg(CFG_ENABLE, 2'd1);
    write_reg(CFG_MODE, MODE_HR);
    calm = 1'b1;
    send_word(KIND_CLEAR, $urandom_range(0, 255));
    repeat (TAIL_RECORDS * REC_BYTES + $urandom_range(0, 5))
      send_word(KIND_WRITE, $urandom_range(0, 255));
    while (img_unread >= REC_BYTES)
      send_word(KIND_READ, $urandom_range(0, 255));
    send_word(KIND_READ, $urandom_range(0, 255));

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
